### rtl/gld_pkg.sv
`default_nettype none

package gld_pkg;

  // Default sizes of the grid and of one sample.
  localparam int DEF_MAX_ROWS    = 32;
  localparam int DEF_MAX_COLS    = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RST = CFG_DATA_W'(32);

  // Width of the reported row and column indexes.
  localparam int PEAK_IDX_W = 5;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RD    = 6'b000010,
    ST_DEC   = 6'b000100,
    ST_BLOAD = 6'b001000,
    ST_BDEC  = 6'b010000,
    ST_FLUSH = 6'b100000
  } gld_state_e;

endpackage

`default_nettype wire

### rtl/grid_local_max_detector.sv
`default_nettype none

// Streaming 4-neighbour local maximum finder. Samples of a grid_rows by grid_cols grid arrive
// in raster order on the sample channel; for every sample that is greater than or equal to
// each of its existing up, down, left and right neighbours the block returns its row and
// column on the peak channel, in raster order, with run_last marking the final result
// caused by one input beat. Neighbours outside the grid are not compared, so a one-row or
// one-column grid works as expected. Pixel (i,j) of a row before the last is decided when
// sample (i+1,j) arrives; the peaks of the last row follow as a burst after the final
// sample. A register size of zero acts as 1 and a size above MAX_ROWS or MAX_COLS acts as
// that maximum. Any write to a size register restarts the frame; the line buffers keep
// their contents. Each sample passes through ST_IDLE (read the two line buffers at the
// column), ST_RD (write them back and read the side neighbours) and ST_DEC (decide), since
// both buffers are single-read-port RAMs with a registered read; a new sample is taken only
// in ST_IDLE. The last-row burst after the final sample sweeps the buffers one column per
// cycle, but waits while a held-back result meets a full output register.
module grid_local_max_detector
  #(
  parameter int MAX_ROWS    = gld_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = gld_pkg::DEF_MAX_COLS,
  parameter int SAMPLE_BITS = gld_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gld_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gld_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Sample input channel.
  input  logic                                sample_valid_i,
  output logic                                sample_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  // Peak result channel.
  output logic                                peak_valid_o,
  input  logic                                peak_ready_i,
  output logic [gld_pkg::PEAK_IDX_W-1:0]      peak_row_o,
  output logic [gld_pkg::PEAK_IDX_W-1:0]      peak_col_o,
  output logic                                run_last_o
);

  import gld_pkg::*;

  localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RSW = $clog2(MAX_ROWS + 1);
  localparam int CSW = $clog2(MAX_COLS + 1);

  // Size registers and their clamped values.
  logic [CFG_DATA_W-1:0] grid_rows_q, grid_cols_q;
  logic [RSW-1:0]        rows_eff;
  logic [CSW-1:0]        cols_eff;
  logic                  cfg_hit;

  // Raster position.
  logic [RSW-1:0] row_cnt_q, row_cnt_d, pos_row, i_q;
  logic [CSW-1:0] col_cnt_q, col_cnt_d, pos_col, j_q;
  logic           pos_wrap, pos_last, pos_eol;
  logic           last_pix_q;
  logic           in_take;

  // Sequencer.
  gld_state_e     state_q, state_d;
  logic [CSW-1:0] k_q, k_d;

  // Sample and neighbour window. In the per-sample path c_q is the pixel being decided
  // and up_q its upper neighbour; in the burst left_q also holds the left neighbour.
  logic signed [SAMPLE_BITS-1:0] cur_q, c_q, up_q, left_q;
  logic signed [SAMPLE_BITS-1:0] new_rd_s, old_rd_s;
  logic                          win_load, win_adv;

  // Line buffer RAM ports.
  logic                   new_we, old_we;
  logic [AW-1:0]          new_waddr, old_waddr, new_raddr, old_raddr;
  logic [SAMPLE_BITS-1:0] new_wdata, old_wdata, new_rdata, old_rdata;

  // Peak decisions.
  logic dec_peak, bur_peak;

  // One result waits here until it is known whether it is the last of its beat.
  logic                  pend_valid_q, pend_valid_d;
  logic [PEAK_IDX_W-1:0] pend_row_q, pend_row_d, pend_col_q, pend_col_d;

  // Output register.
  logic                  out_valid_q, out_free, out_load;
  logic [PEAK_IDX_W-1:0] out_row_q, out_row_d, out_col_q, out_col_d;
  logic                  out_last_q, out_last_d;

  // ---------------------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------------------

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i && cfg_ready_o &&
                       (cfg_index_i == REG_GRID_ROWS || cfg_index_i == REG_GRID_COLS);

  always_comb begin
    if (grid_rows_q == '0) begin
      rows_eff = RSW'(1);
    end else if (32'(grid_rows_q) > MAX_ROWS) begin
      rows_eff = RSW'(MAX_ROWS);
    end else begin
      rows_eff = RSW'(grid_rows_q);
    end
    if (grid_cols_q == '0) begin
      cols_eff = CSW'(1);
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      cols_eff = CSW'(MAX_COLS);
    end else begin
      cols_eff = CSW'(grid_cols_q);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Position of the incoming sample
  // ---------------------------------------------------------------------------------------

  // If the counters ever lie outside the grid in use, the frame restarts at the origin.
  assign pos_wrap = (row_cnt_q >= rows_eff) || (col_cnt_q >= cols_eff);
  assign pos_row  = pos_wrap ? '0 : row_cnt_q;
  assign pos_col  = pos_wrap ? '0 : col_cnt_q;
  assign pos_eol  = (pos_col + CSW'(1)) == cols_eff;
  assign pos_last = pos_eol && ((pos_row + RSW'(1)) == rows_eff);

  assign sample_ready_o = (state_q == ST_IDLE);
  assign in_take        = sample_valid_i && sample_ready_o;

  // ---------------------------------------------------------------------------------------
  // Line buffers: "newer" holds the most recent row, "older" the one above it.
  // ---------------------------------------------------------------------------------------

  gld_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLS)
  ) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (new_we),
    .waddr_i (new_waddr),
    .wdata_i (new_wdata),
    .raddr_i (new_raddr),
    .rdata_o (new_rdata)
  );

  gld_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLS)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (old_we),
    .waddr_i (old_waddr),
    .wdata_i (old_wdata),
    .raddr_i (old_raddr),
    .rdata_o (old_rdata)
  );

  assign new_rd_s  = $signed(new_rdata);
  assign old_rd_s  = $signed(old_rdata);
  assign new_waddr = j_q[AW-1:0];
  assign old_waddr = j_q[AW-1:0];
  assign new_wdata = cur_q;
  assign old_wdata = new_rdata;

  // ---------------------------------------------------------------------------------------
  // Peak decisions
  // ---------------------------------------------------------------------------------------

  // Pixel (i-1, j): the read data here are its right neighbour (newer) and its left
  // neighbour (older, moved there by the previous sample), and the current sample is the
  // pixel below it.
  always_comb begin
    dec_peak = (i_q != '0) && (c_q >= cur_q);
    if ((32'(i_q) >= 32'd2) && (c_q < up_q)) begin
      dec_peak = 1'b0;
    end
    if ((j_q != '0) && (c_q < old_rd_s)) begin
      dec_peak = 1'b0;
    end
    if (((j_q + CSW'(1)) < cols_eff) && (c_q < new_rd_s)) begin
      dec_peak = 1'b0;
    end
  end

  // Last-row pixel k: the read data are the column to its right.
  always_comb begin
    bur_peak = 1'b1;
    if ((rows_eff != RSW'(1)) && (c_q < up_q)) begin
      bur_peak = 1'b0;
    end
    if ((k_q != '0) && (c_q < left_q)) begin
      bur_peak = 1'b0;
    end
    if (((k_q + CSW'(1)) < cols_eff) && (c_q < new_rd_s)) begin
      bur_peak = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------------

  assign out_free = !out_valid_q || peak_ready_i;

  always_comb begin
    state_d      = state_q;
    row_cnt_d    = row_cnt_q;
    col_cnt_d    = col_cnt_q;
    k_d          = k_q;
    pend_valid_d = pend_valid_q;
    pend_row_d   = pend_row_q;
    pend_col_d   = pend_col_q;
    out_load     = 1'b0;
    out_row_d    = pend_row_q;
    out_col_d    = pend_col_q;
    out_last_d   = 1'b0;
    new_we       = 1'b0;
    old_we       = 1'b0;
    new_raddr    = pos_col[AW-1:0];
    old_raddr    = pos_col[AW-1:0];
    win_load     = 1'b0;
    win_adv      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        // The column of the incoming sample is read from both buffers.
        if (in_take) begin
          if (pos_last) begin
            row_cnt_d = '0;
            col_cnt_d = '0;
          end else if (pos_eol) begin
            row_cnt_d = pos_row + RSW'(1);
            col_cnt_d = '0;
          end else begin
            row_cnt_d = pos_row;
            col_cnt_d = pos_col + CSW'(1);
          end
          state_d = ST_RD;
        end
      end

      ST_RD: begin
        // Shift the column down one row and fetch the side neighbours.
        new_we    = 1'b1;
        old_we    = 1'b1;
        win_load  = 1'b1;
        new_raddr = AW'(32'(j_q) + 32'd1);
        old_raddr = AW'(32'(j_q) - 32'd1);
        state_d   = ST_DEC;
      end

      ST_DEC: begin
        new_raddr = '0;
        old_raddr = '0;
        if (dec_peak) begin
          if (last_pix_q || !out_free) begin
            pend_valid_d = 1'b1;
            pend_row_d   = PEAK_IDX_W'(32'(i_q) - 32'd1);
            pend_col_d   = PEAK_IDX_W'(32'(j_q));
          end else begin
            out_load   = 1'b1;
            out_row_d  = PEAK_IDX_W'(32'(i_q) - 32'd1);
            out_col_d  = PEAK_IDX_W'(32'(j_q));
            out_last_d = 1'b1;
          end
        end
        if (last_pix_q) begin
          state_d = ST_BLOAD;
        end else if (dec_peak && !out_free) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_BLOAD: begin
        // Column zero arrives; column one is requested.
        win_load  = 1'b1;
        k_d       = '0;
        new_raddr = AW'(32'd1);
        old_raddr = AW'(32'd1);
        state_d   = ST_BDEC;
      end

      ST_BDEC: begin
        if (bur_peak && pend_valid_q && !out_free) begin
          // Hold the read address so the neighbour data stay in place.
          new_raddr = AW'(32'(k_q) + 32'd1);
          old_raddr = AW'(32'(k_q) + 32'd1);
        end else begin
          new_raddr = AW'(32'(k_q) + 32'd2);
          old_raddr = AW'(32'(k_q) + 32'd2);
          win_adv   = 1'b1;
          k_d       = k_q + CSW'(1);
          if (bur_peak) begin
            out_load     = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_row_d   = PEAK_IDX_W'(32'(i_q));
            pend_col_d   = PEAK_IDX_W'(32'(k_q));
          end
          if ((k_q + CSW'(1)) == cols_eff) begin
            state_d = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        // The result still held back is the last one of this beat.
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A write to a size register starts a new frame.
    if (cfg_hit) begin
      row_cnt_d = '0;
      col_cnt_d = '0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      grid_rows_q  <= GRID_SIZE_RST;
      grid_cols_q  <= GRID_SIZE_RST;
      row_cnt_q    <= '0;
      col_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_cnt_q    <= row_cnt_d;
      col_cnt_q    <= col_cnt_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == REG_GRID_ROWS) begin
        grid_rows_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == REG_GRID_COLS) begin
        grid_cols_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (peak_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cur_q      <= sample_i;
      i_q        <= pos_row;
      j_q        <= pos_col;
      last_pix_q <= pos_last;
    end
    if (win_load || win_adv) begin
      c_q  <= new_rd_s;
      up_q <= old_rd_s;
    end
    if (win_adv) begin
      left_q <= c_q;
    end
    k_q        <= k_d;
    pend_row_q <= pend_row_d;
    pend_col_q <= pend_col_d;
    if (out_load) begin
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_last_q <= out_last_d;
    end
  end

  assign peak_valid_o = out_valid_q;
  assign peak_row_o   = out_row_q;
  assign peak_col_o   = out_col_q;
  assign run_last_o   = out_last_q;

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------

  // Every held-back result has left before the next sample can be taken.
  a_pend_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_valid_q)
    else $error("pending result left over in idle");

  // A size register write restarts the frame.
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (row_cnt_q == '0) && (col_cnt_q == '0))
    else $error("size write did not restart the frame");

  // The raster counters never leave the grid in use.
  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_cnt_q < rows_eff) && (col_cnt_q < cols_eff))
    else $error("raster position outside the grid");

endmodule

`default_nettype wire

### rtl/gld_ram.sv
`default_nettype none

module gld_ram #(
  parameter int WIDTH = gld_pkg::DEF_SAMPLE_BITS,
  parameter int DEPTH = gld_pkg::DEF_MAX_COLS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
